[rtl/core/marker_center_velocity_shaper_core_assert.svh]
// ---------------------------------------------------------------------------
// marker center velocity shaper assertion macros
// Shared concurrent assertion forms, clocked and disabled under reset.
// ---------------------------------------------------------------------------
`ifndef MARKER_CENTER_VELOCITY_SHAPER_CORE_ASSERT_SVH
`define MARKER_CENTER_VELOCITY_SHAPER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MCVS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MCVS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mcvs_pkg.sv]
// ---------------------------------------------------------------------------
// mcvs_pkg
// Shared widths, register indexes and lane interface types.
// ---------------------------------------------------------------------------
`default_nettype none

package mcvs_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] REG_DEADBAND = 3'd0;
  localparam logic [2:0] REG_GAIN_X   = 3'd1;
  localparam logic [2:0] REG_GAIN_Y   = 3'd2;
  localparam logic [2:0] REG_SPEED    = 3'd3;
  localparam logic [2:0] REG_FLIP_LAT = 3'd4;
  localparam logic [2:0] REG_FLIP_FWD = 3'd5;
  localparam logic [2:0] REG_WEIGHT   = 3'd6;
  localparam logic [2:0] REG_SLEW     = 3'd7;

  // input operation codes
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // smoothing weight floor, 0.05 in Q0.16
  localparam logic [16:0] WEIGHT_MIN = 17'd3277;

  // per-lane configuration view
  typedef struct packed {
    logic [15:0]        deadband;
    logic signed [15:0] gain;
    logic [14:0]        speed_limit;
    logic               flip;
    logic [15:0]        weight;
    logic               weight_one;
    logic [14:0]        slew;
  } lane_cfg_t;

  // step enables from the sequencer to the lanes
  typedef struct packed {
    logic load;
    logic mul;
    logic tgt;
    logic ema;
    logic fin;
    logic clear;
  } lane_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/mcvs_lane.sv]
// ---------------------------------------------------------------------------
// mcvs_lane
// One axis: deadband, gain, clamp, flip, EMA smoothing and slew limit.
// ---------------------------------------------------------------------------
`default_nettype none

module mcvs_lane (
  input  wire                       clk,
  input  wire                       rst,
  input  mcvs_pkg::lane_ctrl_t      ctrl,
  input  mcvs_pkg::lane_cfg_t       cfg,
  input  wire                       seen,
  input  wire logic signed [15:0]   error,
  output logic signed [15:0]        held,
  output logic signed [15:0]        held_next
);
  import mcvs_pkg::*;

  logic signed [15:0] err_q;
  logic signed [31:0] prod_q;
  logic signed [15:0] tgt_q;
  logic signed [33:0] ema_q;

  logic signed [16:0] err_ext;
  logic [16:0]        err_mag;
  logic               in_dead;
  logic signed [32:0] rnd_sum;
  logic signed [21:0] tgt_full;
  logic signed [21:0] lim;
  logic signed [21:0] tgt_clamp;
  logic signed [15:0] tgt_flip;
  logic signed [16:0] delta;
  logic signed [17:0] weight_s;
  logic signed [33:0] ema_sum;
  logic signed [17:0] step;
  logic signed [17:0] slew_s;
  logic signed [17:0] step_lim;
  logic signed [17:0] held_sum;

  // deadband on the error magnitude
  always_comb begin
    err_ext = {error[15], error};
    err_mag = err_ext[16] ? 17'(-err_ext) : 17'(err_ext);
    in_dead = err_mag < {1'b0, cfg.deadband};
  end

  // gain product rounded half up to Q4.12, clamped and optionally negated
  always_comb begin
    rnd_sum  = {prod_q[31], prod_q} + 33'sd1024;
    tgt_full = rnd_sum[32:11];
    lim      = $signed({7'b0, cfg.speed_limit});
    if (tgt_full > lim) begin
      tgt_clamp = lim;
    end else if (tgt_full < -lim) begin
      tgt_clamp = -lim;
    end else begin
      tgt_clamp = tgt_full;
    end
    tgt_flip = cfg.flip ? -tgt_clamp[15:0] : tgt_clamp[15:0];
  end

  // EMA step toward the target, then slew limit against the held value
  always_comb begin
    delta    = {tgt_q[15], tgt_q} - {held[15], held};
    weight_s = $signed({2'b0, cfg.weight});
    ema_sum  = ema_q + 34'sd32768;
    step     = cfg.weight_one ? {delta[16], delta} : ema_sum[33:16];
    slew_s   = $signed({3'b0, cfg.slew});
    step_lim = step;
    if (cfg.slew != '0) begin
      if (step > slew_s) begin
        step_lim = slew_s;
      end else if (step < -slew_s) begin
        step_lim = -slew_s;
      end
    end
    held_sum  = {{2{held[15]}}, held} + step_lim;
    held_next = held_sum[15:0];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      err_q <= (seen && !in_dead) ? error : '0;
    end
    if (ctrl.mul) begin
      prod_q <= err_q * cfg.gain;
    end
    if (ctrl.tgt) begin
      tgt_q <= tgt_flip;
    end
    if (ctrl.ema) begin
      ema_q <= delta * weight_s;
    end
  end

  // held output
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (ctrl.fin) begin
      held <= ctrl.clear ? '0 : held_sum[15:0];
    end
  end

endmodule

`default_nettype wire

[rtl/core/mcvs_merge.sv]
// ---------------------------------------------------------------------------
// mcvs_merge
// Joins the two lane results into one output transfer with its own register.
// ---------------------------------------------------------------------------
`default_nettype none

module mcvs_merge (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      load,
  input  wire                      zero,
  input  wire logic signed [15:0]  fwd_held,
  input  wire logic signed [15:0]  lat_held,
  output logic                     free,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic signed [15:0]       forward_velocity,
  output logic signed [15:0]       lateral_velocity
);
  import mcvs_pkg::*;

  // output register can take a new result
  assign free = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, no command while the marker is lost or on clear
  always_ff @(posedge clk) begin
    if (load) begin
      forward_velocity <= zero ? '0 : fwd_held;
      lateral_velocity <= zero ? '0 : lat_held;
    end
  end

endmodule

`default_nettype wire

[rtl/core/marker_center_velocity_shaper_core.sv]
// ---------------------------------------------------------------------------
// marker_center_velocity_shaper_core
// Marker error to forward and lateral velocity commands, two axis lanes.
// ---------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid / in_ready  operation, marker_seen, error_x, error_y
//  out      output     out_valid/out_ready  forward_velocity, lateral_velocity
//  cfg      input      cfg_write            cfg_index, cfg_data
//
//  After its input transfer an item passes the sequencer states multiply, target,
//  EMA product and final update, stepped through both lanes together, and the
//  result is then loaded into the output register; in_ready returns once the
//  sequencer is back in idle, so one item is in flight at a time.
//  Synchronous reset clears held outputs, sequencer and out_valid, presets config.
//  A stalled output holds the final step until the output register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module marker_center_velocity_shaper_core (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire                      operation,
  input  wire                      marker_seen,
  input  wire logic signed [15:0]  error_x,
  input  wire logic signed [15:0]  error_y,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic signed [15:0]       forward_velocity,
  output logic signed [15:0]       lateral_velocity,
  input  wire                      cfg_write,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [16:0]         cfg_data
);
  import mcvs_pkg::*;

`include "marker_center_velocity_shaper_core_assert.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_TGT  = 3'd2;
  localparam logic [2:0] ST_EMA  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic               op_clear;
  logic               seen_q;
  logic               accept;
  logic               merge_free;
  logic               fin_go;

  logic [15:0]        error_deadband;
  logic signed [15:0] gain_x;
  logic signed [15:0] gain_y;
  logic [14:0]        speed_limit;
  logic               flip_lateral;
  logic               flip_forward;
  logic [16:0]        smoothing_weight;
  logic [14:0]        slew_limit;

  lane_cfg_t          cfg_lat;
  lane_cfg_t          cfg_fwd;
  lane_ctrl_t         ctrl;
  logic [15:0]        weight_use;
  logic signed [15:0] held_fwd;
  logic signed [15:0] held_lat;
  logic signed [15:0] fwd_next;
  logic signed [15:0] lat_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      error_deadband   <= 16'd0;
      gain_x           <= 16'sd256;
      gain_y           <= 16'sd256;
      speed_limit      <= 15'd4096;
      flip_lateral     <= 1'b0;
      flip_forward     <= 1'b0;
      smoothing_weight <= 17'd65536;
      slew_limit       <= 15'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEADBAND: error_deadband   <= cfg_data[15:0];
        REG_GAIN_X:   gain_x           <= $signed(cfg_data[15:0]);
        REG_GAIN_Y:   gain_y           <= $signed(cfg_data[15:0]);
        REG_SPEED:    speed_limit      <= cfg_data[14:0];
        REG_FLIP_LAT: flip_lateral     <= cfg_data[0];
        REG_FLIP_FWD: flip_forward     <= cfg_data[0];
        REG_WEIGHT:   smoothing_weight <= cfg_data;
        REG_SLEW:     slew_limit       <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // weight clamped to 0.05..1.0, full weight passes the target through
  assign weight_use = (smoothing_weight < WEIGHT_MIN) ? WEIGHT_MIN[15:0]
                                                      : smoothing_weight[15:0];

  always_comb begin
    cfg_lat = '{deadband: error_deadband, gain: gain_x, speed_limit: speed_limit,
                flip: flip_lateral, weight: weight_use,
                weight_one: smoothing_weight[16], slew: slew_limit};
    cfg_fwd = '{deadband: error_deadband, gain: gain_y, speed_limit: speed_limit,
                flip: flip_forward, weight: weight_use,
                weight_one: smoothing_weight[16], slew: slew_limit};
  end

  // sequencer
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign fin_go   = (state == ST_FIN) && merge_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_MUL;
      ST_MUL:  state_next = ST_TGT;
      ST_TGT:  state_next = ST_EMA;
      ST_EMA:  state_next = ST_FIN;
      ST_FIN:  if (merge_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item flags captured on input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      op_clear <= (operation == OP_CLEAR);
      seen_q   <= marker_seen;
    end
  end

  // lane step enables
  always_comb begin
    ctrl.load  = accept;
    ctrl.mul   = (state == ST_MUL);
    ctrl.tgt   = (state == ST_TGT);
    ctrl.ema   = (state == ST_EMA);
    ctrl.fin   = fin_go;
    ctrl.clear = op_clear;
  end

  mcvs_lane u_lane_lat (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg       (cfg_lat),
    .seen      (marker_seen),
    .error     (error_x),
    .held      (held_lat),
    .held_next (lat_next)
  );

  mcvs_lane u_lane_fwd (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg       (cfg_fwd),
    .seen      (marker_seen),
    .error     (error_y),
    .held      (held_fwd),
    .held_next (fwd_next)
  );

  // the result carries the updated held values
  mcvs_merge u_merge (
    .clk              (clk),
    .rst              (rst),
    .load             (fin_go),
    .zero             (op_clear || !seen_q),
    .fwd_held         (fwd_next),
    .lat_held         (lat_next),
    .free             (merge_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .forward_velocity (forward_velocity),
    .lateral_velocity (lateral_velocity)
  );

  // checks
  `MCVS_ASSERT_NEXT(a_accept_starts, clk, rst, accept, state == ST_MUL, "accept did not start lanes")
  `MCVS_ASSERT_NEXT(a_fin_gives_out, clk, rst, fin_go, out_valid, "final step lost result")
  `MCVS_ASSERT_NEXT(a_clear_zeroes, clk, rst, fin_go && op_clear, held_fwd == 16'sd0 && held_lat == 16'sd0, "clear left held outputs")

endmodule

`default_nettype wire
